// ===== rtl/mfr_pkg.sv =====
`default_nettype none

package mfr_pkg;

  localparam int FINGER_SLOTS = 4;
  localparam int DATA_SLOTS   = 4;
  localparam int LANES        = (FINGER_SLOTS < DATA_SLOTS) ? FINGER_SLOTS : DATA_SLOTS;
  localparam int LANE_IW      = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int WORD_W  = 32;
  localparam int COORD_W = 12;
  localparam int PRES_W  = 4;
  localparam int ID_W    = 2;
  localparam int KIND_W  = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_CONTACT  = 2'd0;
  localparam kind_t KIND_PRIMARY  = 2'd1;
  localparam kind_t KIND_RELEASED = 2'd2;

  localparam logic [PRES_W-1:0] PRES_RELEASE = 4'd0;
  localparam logic [PRES_W-1:0] PRES_MIN     = 4'd1;

  typedef struct packed {
    logic               pend;
    logic               pressed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PRES_W-1:0]  p;
  } lane_rep_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PRES_W-1:0]  p;
    logic [ID_W-1:0]    id;
    logic               first;
    logic               clr;
    logic               last;
  } report_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mfr_lane.sv =====
`default_nettype none

module mfr_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic                      down,
  input  wire logic                      prior,
  input  wire logic [mfr_pkg::WORD_W-1:0] word,
  input  wire logic                      pop,
  output mfr_pkg::lane_rep_t             rep
);
  import mfr_pkg::*;

  logic [COORD_W-1:0] x_st_r, y_st_r;
  logic [PRES_W-1:0]  p_st_r;
  logic [COORD_W-1:0] dx, dy;
  logic [PRES_W-1:0]  dp;
  lane_rep_t          rep_r;

  // x from byte0 and byte2 high nibble, y from byte1 and byte2 low nibble
  assign dx = {word[23:20], word[7:0]};
  assign dy = {word[19:16], word[15:8]};
  assign dp = (word[31:28] == PRES_RELEASE) ? PRES_MIN : word[31:28];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_st_r <= '0;
      y_st_r <= '0;
      p_st_r <= '0;
    end else if (load) begin
      if (down) begin
        x_st_r <= dx;
        y_st_r <= dy;
        p_st_r <= dp;
      end else if (prior) begin
        x_st_r <= '0;
        y_st_r <= '0;
        p_st_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r.pend <= 1'b0;
    end else if (load) begin
      rep_r.pend    <= down | prior;
      rep_r.pressed <= down;
      rep_r.x       <= down ? dx : x_st_r;
      rep_r.y       <= down ? dy : y_st_r;
      rep_r.p       <= down ? dp : PRES_RELEASE;
    end else if (pop) begin
      rep_r.pend <= 1'b0;
    end
  end

  assign rep = rep_r;

endmodule

`default_nettype wire

// ===== rtl/mfr_merge.sv =====
`default_nettype none

module mfr_merge (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire logic                     clr,
  input  wire logic [mfr_pkg::LANES-1:0] down,
  input  wire mfr_pkg::lane_rep_t       reps [mfr_pkg::LANES],
  input  wire logic                     out_stall,
  output logic      [mfr_pkg::LANES-1:0] pop,
  output logic      [mfr_pkg::LANES-1:0] prior,
  output logic                          busy,
  output logic                          out_valid,
  output mfr_pkg::report_t              out_rep
);
  import mfr_pkg::*;

  state_t             state_r, state_nxt;
  logic [LANES-1:0]   prior_r;
  logic               clr_r;
  logic               first_r;
  logic               out_valid_r;
  report_t            out_rep_r, rep_nxt;
  logic               emit;
  logic               out_free;
  logic               any_pend, any_pr;
  logic [LANE_IW-1:0] sel_pend, sel_pr;

  // lowest pending lane and lowest pressed lane
  always_comb begin
    any_pend = 1'b0;
    any_pr   = 1'b0;
    sel_pend = '0;
    sel_pr   = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (reps[i].pend) begin
        any_pend = 1'b1;
        sel_pend = LANE_IW'(i);
      end
      if (reps[i].pressed) begin
        any_pr = 1'b1;
        sel_pr = LANE_IW'(i);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pop       = '0;
    emit      = 1'b0;
    rep_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (any_pend) begin
            pop[sel_pend] = 1'b1;
            rep_nxt.kind  = KIND_CONTACT;
            rep_nxt.x     = reps[sel_pend].x;
            rep_nxt.y     = reps[sel_pend].y;
            rep_nxt.p     = reps[sel_pend].p;
            rep_nxt.id    = ID_W'(sel_pend);
          end else begin
            state_nxt    = ST_IDLE;
            rep_nxt.clr  = clr_r;
            rep_nxt.last = 1'b1;
            if (any_pr) begin
              rep_nxt.kind  = KIND_PRIMARY;
              rep_nxt.x     = reps[sel_pr].x;
              rep_nxt.y     = reps[sel_pr].y;
              rep_nxt.p     = reps[sel_pr].p;
              rep_nxt.id    = ID_W'(sel_pr);
              rep_nxt.first = first_r;
            end else begin
              rep_nxt.kind = KIND_RELEASED;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prior_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        prior_r <= down;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clr_r   <= clr;
      first_r <= (prior_r == '0);
    end
    if (emit) begin
      out_rep_r <= rep_nxt;
    end
  end

  assign prior     = prior_r;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rep   = out_rep_r;

endmodule

`default_nettype wire

// ===== rtl/multitouch_frame_reporter.sv =====
// multitouch frame reporter
// input channel (in_valid / in_stall): one beat is one touch frame, a status
// byte and four packed finger words. output channel (out_valid / out_stall):
// one beat is one report. each frame gives one report per finger that is
// down or was just released, in slot order, then one summary beat with
// out_last set; a frame with in_read_error set is taken and gives nothing.
// all finger words are decoded at once by one lane per slot; the lanes
// hold the stored position and pressure of their finger.
// the lanes register the frame beat; the merge then moves its reports into
// the output register one report per cycle while out_stall allows. in_stall
// stays high while a frame's reports drain, so frames are taken one at a time;
// the next frame is taken once the summary sits in the output register.
// out_stall holds the output register and the drain; nothing is dropped.
// reset (rst_n low, synchronous) clears the touch mask, the finger stores
// and the output valid.
`default_nettype none

module multitouch_frame_reporter (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_read_error,
  input  wire logic [7:0]                      in_status,
  input  wire logic [mfr_pkg::WORD_W-1:0]      in_finger_zero_data,
  input  wire logic [mfr_pkg::WORD_W-1:0]      in_finger_one_data,
  input  wire logic [mfr_pkg::WORD_W-1:0]      in_finger_two_data,
  input  wire logic [mfr_pkg::WORD_W-1:0]      in_finger_three_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [mfr_pkg::KIND_W-1:0]      out_report_kind,
  output logic      [mfr_pkg::COORD_W-1:0]     out_x_position,
  output logic      [mfr_pkg::COORD_W-1:0]     out_y_position,
  output logic      [mfr_pkg::PRES_W-1:0]      out_pressure,
  output logic      [mfr_pkg::ID_W-1:0]        out_finger_id,
  output logic                                 out_first_press,
  output logic                                 out_clear_fifo,
  output logic                                 out_last
);
  import mfr_pkg::*;

  logic [WORD_W-1:0] words [DATA_SLOTS];
  lane_rep_t         reps [LANES];
  logic [LANES-1:0]  pop;
  logic [LANES-1:0]  prior;
  logic              busy;
  logic              load;
  report_t           rep;

  assign words[0] = in_finger_zero_data;
  assign words[1] = in_finger_one_data;
  assign words[2] = in_finger_two_data;
  assign words[3] = in_finger_three_data;

  assign in_stall = busy;
  assign load     = in_valid && !busy && !in_read_error;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mfr_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .load  (load),
      .down  (in_status[g]),
      .prior (prior[g]),
      .word  (words[g]),
      .pop   (pop[g]),
      .rep   (reps[g])
    );
  end

  mfr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .clr       (in_status[4] | in_status[5]),
    .down      (in_status[LANES-1:0]),
    .reps      (reps),
    .out_stall (out_stall),
    .pop       (pop),
    .prior     (prior),
    .busy      (busy),
    .out_valid (out_valid),
    .out_rep   (rep)
  );

  assign out_report_kind = rep.kind;
  assign out_x_position  = rep.x;
  assign out_y_position  = rep.y;
  assign out_pressure    = rep.p;
  assign out_finger_id   = rep.id;
  assign out_first_press = rep.first;
  assign out_clear_fifo  = rep.clr;
  assign out_last        = rep.last;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  typedef struct packed {
    logic                  hold;
    logic                  read_error;
    logic [7:0]            status;
    logic [3:0][WORD_W-1:0] words;
  } touch_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_read_error = 1'b0;
  logic [7:0]          in_status = 8'h00;
  logic [WORD_W-1:0]   in_finger_zero_data = '0;
  logic [WORD_W-1:0]   in_finger_one_data = '0;
  logic [WORD_W-1:0]   in_finger_two_data = '0;
  logic [WORD_W-1:0]   in_finger_three_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   out_report_kind;
  logic [COORD_W-1:0]  out_x_position;
  logic [COORD_W-1:0]  out_y_position;
  logic [PRES_W-1:0]   out_pressure;
  logic [ID_W-1:0]     out_finger_id;
  logic                out_first_press;
  logic                out_clear_fifo;
  logic                out_last;

  multitouch_frame_reporter uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_read_error        (in_read_error),
    .in_status            (in_status),
    .in_finger_zero_data  (in_finger_zero_data),
    .in_finger_one_data   (in_finger_one_data),
    .in_finger_two_data   (in_finger_two_data),
    .in_finger_three_data (in_finger_three_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_report_kind      (out_report_kind),
    .out_x_position       (out_x_position),
    .out_y_position       (out_y_position),
    .out_pressure         (out_pressure),
    .out_finger_id        (out_finger_id),
    .out_first_press      (out_first_press),
    .out_clear_fifo       (out_clear_fifo),
    .out_last             (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_frame_t pending_frames[$];
  report_t      expected_reports[$];
  touch_frame_t driven_frame;

  // predictor state
  logic [3:0]         touch_mask;
  logic [COORD_W-1:0] held_x[4];
  logic [COORD_W-1:0] held_y[4];
  logic [PRES_W-1:0]  held_p[4];

  int errors = 0;
  int frames_queued = 0;
  int frames_taken = 0;
  int error_frames = 0;
  int full_frames = 0;
  int released_summaries = 0;
  int reports_checked = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  task automatic queue_frame(input logic hold, input logic err, input logic [7:0] status,
                             input logic [31:0] w0, input logic [31:0] w1,
                             input logic [31:0] w2, input logic [31:0] w3);
    touch_frame_t f;
    f.hold = hold;
    f.read_error = err;
    f.status = status;
    f.words[0] = w0;
    f.words[1] = w1;
    f.words[2] = w2;
    f.words[3] = w3;
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 5) == 0) w[31:28] = 4'h0;
    return w;
  endfunction

  task automatic predict_reports(input touch_frame_t f);
    report_t            r;
    logic [31:0]        w;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PRES_W-1:0]  p;
    logic               clr;
    logic [3:0]         lane_mask;
    int                 primary;
    int                 count;
    if (f.read_error) begin
      error_frames++;
      return;
    end
    primary = -1;
    count = 0;
    clr = |f.status[5:4];
    lane_mask = 4'((1 << LANES) - 1);
    for (int i = 0; i < LANES; i++) begin
      if (f.status[i]) begin
        w = f.words[i];
        x = {w[23:20], w[7:0]};
        y = {w[19:16], w[15:8]};
        p = w[31:28];
        if (p == PRES_RELEASE) p = PRES_MIN;
        held_x[i] = x;
        held_y[i] = y;
        held_p[i] = p;
        r = '{kind: KIND_CONTACT, x: x, y: y, p: p, id: ID_W'(i),
              first: 1'b0, clr: 1'b0, last: 1'b0};
        expected_reports.push_back(r);
        count++;
        if (primary < 0) primary = i;
      end else if (touch_mask[i]) begin
        r = '{kind: KIND_CONTACT, x: held_x[i], y: held_y[i], p: PRES_RELEASE,
              id: ID_W'(i), first: 1'b0, clr: 1'b0, last: 1'b0};
        expected_reports.push_back(r);
        count++;
        held_x[i] = '0;
        held_y[i] = '0;
        held_p[i] = '0;
      end
    end
    if (primary < 0) begin
      r = '{kind: KIND_RELEASED, x: '0, y: '0, p: PRES_RELEASE, id: '0,
            first: 1'b0, clr: clr, last: 1'b1};
      released_summaries++;
    end else begin
      r = '{kind: KIND_PRIMARY, x: held_x[primary], y: held_y[primary],
            p: held_p[primary], id: ID_W'(primary), first: (touch_mask == 4'h0),
            clr: clr, last: 1'b1};
    end
    expected_reports.push_back(r);
    count++;
    if (count == 5) full_frames++;
    touch_mask = f.status[3:0] & lane_mask;
  endtask

  task automatic check_field(input string what, input logic [11:0] want,
                             input logic [11:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // frame driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_reports(driven_frame);
        frames_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_frames.size() > 0 &&
                     (!pending_frames[0].hold || expected_reports.size() == 0)) begin
          driven_frame = pending_frames.pop_front();
          in_read_error <= driven_frame.read_error;
          in_status <= driven_frame.status;
          in_finger_zero_data <= driven_frame.words[0];
          in_finger_one_data <= driven_frame.words[1];
          in_finger_two_data <= driven_frame.words[2];
          in_finger_three_data <= driven_frame.words[3];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report expected none actual kind %0d x %0h y %0h id %0d",
                   $time, out_report_kind, out_x_position, out_y_position, out_finger_id);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", 12'(want.kind), 12'(out_report_kind));
          check_field("x_position", want.x, out_x_position);
          check_field("y_position", want.y, out_y_position);
          check_field("pressure", 12'(want.p), 12'(out_pressure));
          check_field("finger_id", 12'(want.id), 12'(out_finger_id));
          check_field("first_press", 12'(want.first), 12'(out_first_press));
          check_field("clear_fifo", 12'(want.clr), 12'(out_clear_fifo));
          check_field("last", 12'(want.last), 12'(out_last));
          reports_checked++;
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 150);
      end else begin
        stall_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 7) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= stall_phase[2];
        end
      endcase
    end
  end

  initial begin
    logic [3:0] prev_mask;
    logic [3:0] mask;
    logic [3:0] toggle;
    logic [3:0] upper;
    logic       err;
    int         sel;

    touch_mask = 4'h0;
    for (int i = 0; i < 4; i++) begin
      held_x[i] = '0;
      held_y[i] = '0;
      held_p[i] = '0;
    end

    queue_frame(0, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h01, 32'h0AC35A3C, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h0F, '1, '1, '1, '1);
    queue_frame(0, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 1, 8'hFF, '1, '1, '1, '1);
    queue_frame(0, 0, 8'h30, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'hCA, 32'hFFFFFFFF, 32'hA5A5A5A5, 32'h0, 32'h5A5A5A5A);
    queue_frame(0, 1, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h15, 32'h3C96E187, 32'h0, 32'hF00FF00F, 32'h0);
    queue_frame(1, 0, 8'h20, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h08, 32'h0, 32'h0, 32'h0, 32'h12345678);
    queue_frame(0, 0, 8'h0C, 32'h0, 32'h0, 32'hF0000000, 32'h00FFFFFF);
    queue_frame(0, 0, 8'h04, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h87654321, 32'h0);
    queue_frame(0, 0, 8'hF0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h0F, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_frame(0, 0, 8'h06, 32'h10000FFF, 32'hE0FF0000, 32'h0000FF00, 32'h01F0F0F0);
    queue_frame(0, 0, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);

    // gesture-like streams: often one finger changing at a time
    prev_mask = 4'h0;
    for (int n = 0; n < 365; n++) begin
      sel = $urandom_range(0, 9);
      toggle = 4'b0001 << $urandom_range(0, 3);
      if (sel < 6)
        mask = prev_mask ^ (($urandom_range(0, 2) == 0) ? 4'h0 : toggle);
      else if (sel < 9)
        mask = 4'($urandom);
      else
        mask = 4'h0;
      upper = 4'($urandom);
      if ($urandom_range(0, 2) != 0) upper[1:0] = 2'b00;
      err = ($urandom_range(0, 15) == 0);
      queue_frame(($urandom_range(0, 59) == 0), err, {upper, mask},
                  random_word(), random_word(), random_word(), random_word());
      if (!err) prev_mask = mask;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (frames_taken < frames_queued) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("covered %0d frames: %0d with read errors, %0d giving five reports",
             frames_taken, error_frames, full_frames);
    $display("checked %0d reports, %0d of them all-released summaries",
             reports_checked, released_summaries);
    if (errors == 0) begin
      $display("multitouch_frame_reporter: match");
    end else begin
      $display("multitouch_frame_reporter: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("multitouch_frame_reporter: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/mfr_pkg.sv
rtl/mfr_lane.sv
rtl/mfr_merge.sv
rtl/multitouch_frame_reporter.sv
tb/tb_top.sv
